// File: rtl/tvdmc_pkg.sv
package tvdmc_pkg;

    localparam int PADDR_W = 3;
    localparam int EPS_W   = 16;
    localparam int NUM_W   = 62;
    localparam int DEN_W   = 33;
    localparam int QUO_W   = 33;
    localparam int CNT_W   = 6;

    localparam logic              REG_EPS_IDX = 1'b0;
    localparam logic [EPS_W-1:0]  EPS_RESET   = 16'd1;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // accumulator clamp, +-2^60
    localparam logic signed [63:0] ACC_LIM = 64'sh1000_0000_0000_0000;

    localparam logic signed [31:0] Q_MAX_S = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN_S = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]          axis;
        logic                flux_positive;
        logic                coupled_boundary;
        logic signed [31:0]  value_owner;
        logic signed [31:0]  value_neighbour;
        logic signed [31:0]  owner_centre;
        logic signed [31:0]  neighbour_point;
        logic signed [31:0]  face_centre;
        logic signed [31:0]  grad_owner;
        logic signed [31:0]  grad_neighbour;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  correction;
        logic [17:0]         limiter_value;
        logic                ratio_saturated;
    } t_out_item;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN,
        DV_DONE
    } t_div_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_R,
        S_ACC_R,
        S_ACC_C,
        S_DIV_SETUP,
        S_DIV_WAIT,
        S_LIMIT,
        S_MUL_HI,
        S_MUL_LO,
        S_EMIT
    } t_seq_state;

endpackage

// File: rtl/tvd_mc_face_correction.sv
// Per-axis item: states S_MUL_R, S_ACC_R, S_ACC_C (one shared multiplier, two passes).
// Last (z) item: S_ACC_C goes on to S_DIV_SETUP, S_DIV_WAIT on the 33-step restoring
// divider (skipped for a zero denominator), S_LIMIT, then two more multiplier passes for
// limiter * dot and S_EMIT. Ignored axis code: accepted and dropped while in S_IDLE.
// Input stall stays high while an item is in work; one output register holds a result.
// Synchronous active-low reset clears sums, sequencer and output valid; eps resets to 1.
module tvd_mc_face_correction
    import tvdmc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_data,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready
);

    localparam int LIM_W = FRAC_BITS + 2;
    localparam int R_W   = 34;
    localparam logic [R_W-1:0]   ONE_R   = R_W'(1) << FRAC_BITS;
    localparam logic [R_W:0]     LIM_MAX = (R_W + 1)'(2) << FRAC_BITS;
    localparam logic [LIM_W-1:0] LIM_TOP = {2'b10, {FRAC_BITS{1'b0}}};

    function automatic logic signed [63:0] acc_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [64:0] lim_p;
        s     = {a[63], a} + {b[63], b};
        lim_p = {ACC_LIM[63], ACC_LIM};
        if (s > lim_p) return ACC_LIM;
        if (s < -lim_p) return -ACC_LIM;
        return s[63:0];
    endfunction

    t_seq_state                r_state, n_state;
    logic [EPS_W-1:0]          r_eps;
    logic signed [63:0]        r_ratio_sum;
    logic signed [63:0]        r_corr_sum;
    logic signed [32:0]        r_rv;
    logic signed [32:0]        r_cv;
    logic signed [31:0]        r_g;
    logic signed [33:0]        r_den;
    logic                      r_last;
    logic signed [67:0]        r_prod;
    logic [63:0]               r_phi;
    logic                      r_neg;
    logic signed [31:0]        r_q;
    logic                      r_sat;
    logic [LIM_W-1:0]          r_lim;
    logic                      r_cneg;
    logic [60:0]               r_cmag;
    logic                      r_out_valid;
    t_out_item                 r_out_data;

    logic                      w_in_acc;
    logic                      w_cfg_wr;
    logic                      w_out_free;
    logic                      w_emit;
    logic                      w_mul_en;
    logic                      w_div_start;
    logic signed [33:0]        w_mul_a;
    logic signed [33:0]        w_mul_b;

    // accept-side datapath
    logic signed [32:0]        w_oc, w_np, w_fc, w_vo, w_vn;
    logic signed [32:0]        w_d_no, w_d_fo, w_d_on, w_d_fn, w_dphi;
    logic signed [32:0]        w_rv, w_cv;

    // accumulate
    logic signed [67:0]        w_prod_sh;
    logic signed [63:0]        w_term;

    // division setup
    logic [63:0]               w_rs_abs;
    logic [NUM_W-1:0]          w_nm;
    logic [33:0]               w_dabs;
    logic                      w_den_zero;
    t_div_stat                 w_div_stat;
    logic [QUO_W-1:0]          w_quo;
    logic [QUO_W-1:0]          w_cap;
    logic                      w_qsat;
    logic [QUO_W-1:0]          w_qmag;
    logic [QUO_W-1:0]          w_q33;

    // limiter
    logic signed [R_W-1:0]     w_r;
    logic [R_W-1:0]            w_rc;
    logic [R_W:0]              w_2r;
    logic [R_W-1:0]            w_half;
    logic [R_W:0]              w_m1;
    logic [R_W:0]              w_m2;
    logic [63:0]               w_cabs;

    // final product
    logic [60:0]               w_mhi_full;
    logic [FRAC_BITS-1:0]      w_mlo;
    logic                      w_big;
    logic [63:0]               w_plo;
    logic [63:0]               w_emag;
    logic [63:0]               w_emag_c;
    logic [63:0]               w_c64;
    logic [R_W-1:0]            w_lim_ext;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_pready   = 1'b1;
    assign o_prdata   = (i_paddr[2] == REG_EPS_IDX) ? {16'h0000, r_eps} : 32'h0000_0000;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (w_in_acc && i_in_data.axis != AXIS_NONE) n_state = S_MUL_R;
            S_MUL_R:     n_state = S_ACC_R;
            S_ACC_R:     n_state = S_ACC_C;
            S_ACC_C:     n_state = r_last ? S_DIV_SETUP : S_IDLE;
            S_DIV_SETUP: n_state = w_den_zero ? S_LIMIT : S_DIV_WAIT;
            S_DIV_WAIT:  if (w_div_stat.done) n_state = S_LIMIT;
            S_LIMIT:     n_state = S_MUL_HI;
            S_MUL_HI:    n_state = S_MUL_LO;
            S_MUL_LO:    n_state = S_EMIT;
            S_EMIT:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        w_emit      = (r_state == S_EMIT) && w_out_free;
        w_div_start = (r_state == S_DIV_SETUP) && !w_den_zero;
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        case (r_state)
            S_MUL_R: begin
                w_mul_en = 1'b1;
                w_mul_a  = {r_rv[32], r_rv};
                w_mul_b  = {{2{r_g[31]}}, r_g};
            end
            S_ACC_R: begin
                w_mul_en = 1'b1;
                w_mul_a  = {r_cv[32], r_cv};
                w_mul_b  = {{2{r_g[31]}}, r_g};
            end
            S_MUL_HI: begin
                w_mul_en = 1'b1;
                w_mul_a  = 34'(r_lim);
                w_mul_b  = {2'b00, w_mhi_full[31:0]};
            end
            S_MUL_LO: begin
                w_mul_en = 1'b1;
                w_mul_a  = 34'(r_lim);
                w_mul_b  = 34'(w_mlo);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (w_cfg_wr && i_paddr[2] == REG_EPS_IDX) begin
            r_eps <= i_pwdata[EPS_W-1:0];
        end
    end

    // ---------------- item capture ----------------
    assign w_oc   = {i_in_data.owner_centre[31], i_in_data.owner_centre};
    assign w_np   = {i_in_data.neighbour_point[31], i_in_data.neighbour_point};
    assign w_fc   = {i_in_data.face_centre[31], i_in_data.face_centre};
    assign w_vo   = {i_in_data.value_owner[31], i_in_data.value_owner};
    assign w_vn   = {i_in_data.value_neighbour[31], i_in_data.value_neighbour};
    assign w_d_no = w_np - w_oc;
    assign w_d_fo = w_fc - w_oc;
    assign w_d_on = w_oc - w_np;
    assign w_d_fn = w_fc - w_np;
    assign w_dphi = i_in_data.flux_positive ? (w_vn - w_vo) : (w_vo - w_vn);

    always_comb begin
        if (i_in_data.coupled_boundary) begin
            w_rv = i_in_data.flux_positive ? w_d_fo : w_d_no;
            w_cv = w_rv;
        end else if (i_in_data.flux_positive) begin
            w_rv = w_d_no;
            w_cv = w_d_fo;
        end else begin
            w_rv = w_d_on;
            w_cv = w_d_fn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_data.axis != AXIS_NONE) begin
            r_rv   <= w_rv;
            r_cv   <= w_cv;
            r_g    <= i_in_data.flux_positive ? i_in_data.grad_owner
                                              : i_in_data.grad_neighbour;
            r_den  <= {w_dphi[32], w_dphi} + {18'h0_0000, r_eps};
            r_last <= (i_in_data.axis == AXIS_Z);
        end
    end

    // ---------------- shared multiplier ----------------
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (r_state == S_MUL_LO) begin
            r_phi <= r_prod[63:0];
        end
    end

    // ---------------- dot sums ----------------
    assign w_prod_sh = r_prod >>> FRAC_BITS;
    assign w_term    = w_prod_sh[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_sum <= '0;
            r_corr_sum  <= '0;
        end else if ((w_in_acc && i_in_data.axis == AXIS_X) || w_emit) begin
            r_ratio_sum <= '0;
            r_corr_sum  <= '0;
        end else if (r_state == S_ACC_R) begin
            r_ratio_sum <= acc_sat(r_ratio_sum, w_term);
        end else if (r_state == S_ACC_C) begin
            r_corr_sum  <= acc_sat(r_corr_sum, w_term);
        end
    end

    // ---------------- ratio quotient ----------------
    assign w_rs_abs   = r_ratio_sum[63] ? (-r_ratio_sum) : r_ratio_sum;
    assign w_nm       = {w_rs_abs[NUM_W-2:0], 1'b0};
    assign w_dabs     = r_den[33] ? (-r_den) : r_den;
    assign w_den_zero = (r_den == '0);

    tvdmc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_nm),
        .i_den   (w_dabs[DEN_W-1:0]),
        .o_stat  (w_div_stat),
        .o_quo   (w_quo)
    );

    assign w_cap  = r_neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    assign w_qsat = w_div_stat.ovf || (w_quo > w_cap);
    assign w_qmag = w_qsat ? w_cap : w_quo;
    assign w_q33  = r_neg ? (-w_qmag) : w_qmag;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV_SETUP) begin
            r_neg <= r_ratio_sum[63] != r_den[33];
            if (w_den_zero) begin
                r_q   <= r_ratio_sum[63] ? Q_MIN_S : Q_MAX_S;
                r_sat <= 1'b1;
            end
        end else if (r_state == S_DIV_WAIT && w_div_stat.done) begin
            r_q   <= w_q33[31:0];
            r_sat <= w_qsat;
        end
    end

    // ---------------- MC limiter ----------------
    assign w_r    = {{2{r_q[31]}}, r_q} + ONE_R;
    assign w_rc   = w_r[R_W-1] ? '0 : w_r;
    assign w_2r   = {w_rc, 1'b0};
    assign w_half = (ONE_R + w_rc) >> 1;
    assign w_m1   = (w_2r < {1'b0, w_half}) ? w_2r : {1'b0, w_half};
    assign w_m2   = (w_m1 < LIM_MAX) ? w_m1 : LIM_MAX;
    assign w_cabs = r_corr_sum[63] ? (-r_corr_sum) : r_corr_sum;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LIMIT) begin
            r_lim  <= w_m2[LIM_W-1:0];
            r_cneg <= r_corr_sum[63];
            r_cmag <= w_cabs[60:0];
        end
    end

    // ---------------- correction ----------------
    assign w_mhi_full = r_cmag >> FRAC_BITS;
    assign w_mlo      = r_cmag[FRAC_BITS-1:0];
    assign w_big      = (w_mhi_full[60:32] != '0) && (r_lim != '0);
    assign w_plo      = r_prod[63:0] >> FRAC_BITS;
    assign w_emag     = r_phi + w_plo;
    assign w_lim_ext  = R_W'(r_lim);

    always_comb begin
        if (r_cneg) begin
            w_emag_c = (w_big || w_emag > 64'h8000_0000) ? 64'h8000_0000 : w_emag;
            w_c64    = -w_emag_c;
        end else begin
            w_emag_c = (w_big || w_emag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : w_emag;
            w_c64    = w_emag_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data.correction      <= w_c64[31:0];
            r_out_data.limiter_value   <= w_lim_ext[17:0];
            r_out_data.ratio_saturated <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ratio_sum <= ACC_LIM) && (r_ratio_sum >= -ACC_LIM)
        && (r_corr_sum <= ACC_LIM) && (r_corr_sum >= -ACC_LIM))
        else $error("dot sum outside clamp range");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT))
        else $error("output beat without emit");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished with no consumer");

    a_lim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_HI) |-> (r_lim <= LIM_TOP))
        else $error("limiter above two");

    a_sums_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_ratio_sum == '0) && (r_corr_sum == '0))
        else $error("sums not cleared after result");
`endif

endmodule

// File: rtl/tvdmc_div.sv
module tvdmc_div
    import tvdmc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output t_div_stat         o_stat,
    output logic [QUO_W-1:0]  o_quo
);

    localparam int NW = NUM_W + FRAC_BITS;

    t_div_state         r_state, n_state;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_sh;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_ovf;

    logic [NW-1:0]      w_n;
    logic [NUM_W-1:0]   w_den_sh;
    logic               w_ovf;
    logic [DEN_W:0]     w_rem_sh;
    logic [DEN_W+1:0]   w_diff;
    logic               w_qb;

    assign w_n      = {r_num, {FRAC_BITS{1'b0}}};
    assign w_den_sh = NUM_W'(r_den) << (QUO_W - FRAC_BITS);
    assign w_ovf    = (r_num >= w_den_sh);
    assign w_rem_sh = {r_rem, r_sh[QUO_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_qb     = ~w_diff[DEN_W+1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE:  if (i_start) n_state = DV_CHECK;
            DV_CHECK: n_state = w_ovf ? DV_DONE : DV_RUN;
            DV_RUN:   if (r_cnt == CNT_W'(1)) n_state = DV_DONE;
            DV_DONE:  n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        o_stat.done = (r_state == DV_DONE);
        o_stat.ovf  = r_ovf;
        o_quo       = r_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == DV_CHECK) begin
                r_cnt <= CNT_W'(QUO_W);
            end else if (r_state == DV_RUN) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_num <= i_num;
                    r_den <= i_den;
                end
            end
            DV_CHECK: begin
                r_ovf <= w_ovf;
                r_rem <= w_n[2*QUO_W-1:QUO_W];
                r_sh  <= w_n[QUO_W-1:0];
            end
            DV_RUN: begin
                r_rem <= w_qb ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                r_sh  <= {r_sh[QUO_W-2:0], w_qb};
            end
            default: begin
            end
        endcase
    end

endmodule

// File: dv/tb_tvd_mc_face_correction.sv
`timescale 1ns / 100ps

module tb_tvd_mc_face_correction;
    import tvdmc_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int IDLE_LIMIT  = 4000;
    localparam int LAT_TAIL    = 64;
    localparam int PHASE_ITEMS = 320;
    localparam int ACC_RUN_LEN = 150;

    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam longint unsigned QMAG_MAX = 64'h7FFF_FFFF;
    localparam longint unsigned QMAG_MIN = 64'h8000_0000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_item            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    logic [EPS_W-1:0] eps_shadow = EPS_RESET;
    longint           ratio_dot_acc = 0;
    longint           corr_dot_acc = 0;

    t_in_item  pending_items[$];
    t_out_item exp_corrections[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_stim = 0;
    int n_fail = 0;
    int src_gap_mode = 1;
    int sink_stall_mode = 1;
    int gap_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    bit drain_hold = 1'b0;

    tvd_mc_face_correction #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_pready    (pready)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic longint acc_clamp(longint a);
        if (a > ACC_LIM) return ACC_LIM;
        if (a < -ACC_LIM) return -ACC_LIM;
        return a;
    endfunction

    // updates the dot-product sums; on the z beat queues the limited correction
    function automatic void face_correction_predict(t_in_item it);
        longint vo, vn, oc, np, fc, rv, cv, g, dphi, den, num, q, r, lim, t, one;
        longint unsigned nm, dm, qi, rem, cap, mag, lm, cm, mhi, mlo;
        bit neg, sat;
        t_out_item res;
        one = longint'(1) <<< FRAC_BITS;
        sat = 1'b0;
        if (it.axis == AXIS_NONE) return;
        if (it.axis == AXIS_X) begin
            ratio_dot_acc = 0;
            corr_dot_acc = 0;
        end
        vo = $signed(it.value_owner);
        vn = $signed(it.value_neighbour);
        oc = $signed(it.owner_centre);
        np = $signed(it.neighbour_point);
        fc = $signed(it.face_centre);
        if (it.coupled_boundary) begin
            rv = it.flux_positive ? fc - oc : np - oc;
            cv = rv;
        end else if (it.flux_positive) begin
            rv = np - oc;
            cv = fc - oc;
        end else begin
            rv = oc - np;
            cv = fc - np;
        end
        if (it.flux_positive) g = $signed(it.grad_owner);
        else g = $signed(it.grad_neighbour);
        ratio_dot_acc = acc_clamp(ratio_dot_acc + ((rv * g) >>> FRAC_BITS));
        corr_dot_acc = acc_clamp(corr_dot_acc + ((cv * g) >>> FRAC_BITS));
        if (it.axis != AXIS_Z) return;

        dphi = it.flux_positive ? vn - vo : vo - vn;
        den = dphi + longint'(eps_shadow);
        num = 2 * ratio_dot_acc;
        if (den == 0) begin
            sat = 1'b1;
            q = (num < 0) ? -longint'(QMAG_MIN) : longint'(QMAG_MAX);
        end else begin
            nm = (num < 0) ? -num : num;
            dm = (den < 0) ? -den : den;
            neg = (num < 0) != (den < 0);
            cap = neg ? QMAG_MIN : QMAG_MAX;
            qi = nm / dm;
            rem = nm % dm;
            if (qi > (cap >> FRAC_BITS)) begin
                sat = 1'b1;
                mag = cap;
            end else begin
                mag = (qi << FRAC_BITS) + ((rem << FRAC_BITS) / dm);
                if (mag > cap) begin
                    sat = 1'b1;
                    mag = cap;
                end
            end
            q = neg ? -longint'(mag) : longint'(mag);
        end

        r = q + one;
        if (r < 0) r = 0;
        lim = 2 * r;
        t = (one + r) >>> 1;
        if (t < lim) lim = t;
        if (2 * one < lim) lim = 2 * one;

        lm = lim;
        cm = (corr_dot_acc < 0) ? -corr_dot_acc : corr_dot_acc;
        mhi = cm >> FRAC_BITS;
        mlo = cm & ((64'd1 << FRAC_BITS) - 64'd1);
        if (lm == 0) mag = 0;
        else if (mhi >= (64'd1 << 32)) mag = 64'd1 << 32;
        else mag = lm * mhi + ((lm * mlo) >> FRAC_BITS);
        if (corr_dot_acc < 0) begin
            if (mag > QMAG_MIN) mag = QMAG_MIN;
            t = -longint'(mag);
        end else begin
            if (mag > QMAG_MAX) mag = QMAG_MAX;
            t = longint'(mag);
        end

        res.correction = t[31:0];
        res.limiter_value = lm[17:0];
        res.ratio_saturated = sat;
        exp_corrections.push_back(res);
        ratio_dot_acc = 0;
        corr_dot_acc = 0;
    endfunction

    function automatic int pick_gap(int mode);
        int roll;
        if (mode == 0) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 3) return $urandom_range(12, 50);
        if (roll < ((mode == 1) ? 20 : 50)) return $urandom_range(1, 4);
        return 0;
    endfunction

    function automatic int rand_q();
        case ($urandom_range(0, 15))
            0: return Q_MAX_S;
            1: return Q_MIN_S;
            2: return 0;
            3, 4: return $urandom;
            5, 6, 7: return int'($urandom_range(0, 1 << 17)) - (1 << 16);
            default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    task automatic push_item(input int axis, input bit fp, input bit cb,
                             input int vo, input int vn, input int oc, input int np,
                             input int fc, input int go, input int gn);
        t_in_item it;
        it.axis = 2'(axis);
        it.flux_positive = fp;
        it.coupled_boundary = cb;
        it.value_owner = vo;
        it.value_neighbour = vn;
        it.owner_centre = oc;
        it.neighbour_point = np;
        it.face_centre = fc;
        it.grad_owner = go;
        it.grad_neighbour = gn;
        pending_items.push_back(it);
        n_queued++;
        if (it.axis != AXIS_NONE) n_stim++;
    endtask

    task automatic push_face(input bit with_x, input bit with_z);
        bit fp, cb, item_fp, item_cb;
        int vo, vn, vn_item;
        fp = 1'($urandom_range(0, 1));
        cb = ($urandom_range(0, 3) == 0);
        vo = rand_q();
        vn = rand_q();
        for (int a = with_x ? 0 : 1; a <= (with_z ? 2 : 1); a++) begin
            item_fp = ($urandom_range(0, 9) == 0) ? ~fp : fp;
            item_cb = ($urandom_range(0, 9) == 0) ? ~cb : cb;
            vn_item = vn;
            // force a zero denominator now and then
            if (a == 2 && $urandom_range(0, 7) == 0)
                vn_item = item_fp ? vo - int'(eps_shadow) : vo + int'(eps_shadow);
            push_item(a, item_fp, item_cb, vo, vn_item,
                      rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
        end
    endtask

    task automatic push_random_sequence();
        case ($urandom_range(0, 19))
            0: push_item(AXIS_NONE, 1'($urandom), 1'($urandom), rand_q(), rand_q(),
                         rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
            1: push_face(1'b0, 1'b1);
            2: push_face(1'b1, 1'b0);
            3: push_face(1'b0, 1'b0);
            default: push_face(1'b1, 1'b1);
        endcase
    endtask

    // y-beat run at full scale: large sums; correction saturates for positive grad
    task automatic push_acc_run(input int grad);
        push_item(AXIS_X, 1'b1, 1'b1, 0, 0, Q_MIN_S, 0, Q_MAX_S, grad, 0);
        for (int i = 0; i < ACC_RUN_LEN; i++)
            push_item(AXIS_Y, 1'b1, 1'b1, 0, 0, Q_MIN_S, 0, Q_MAX_S, grad, 0);
        push_item(AXIS_Z, 1'b1, 1'b1, 0, ONE, Q_MIN_S, 0, Q_MAX_S, grad, 0);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || exp_corrections.size() != 0) @(posedge clk);
        repeat (LAT_TAIL) @(posedge clk);
    endtask

    task automatic start_phase(input logic [EPS_W-1:0] eps, input int gap_mode,
                               input int stall_mode);
        wait_idle();
        write_reg(PADDR_W'(4 * int'(REG_EPS_IDX)), {16'd0, eps});
        eps_shadow = eps;
        src_gap_mode = gap_mode;
        sink_stall_mode = stall_mode;
    endtask

    task automatic random_phase(input logic [EPS_W-1:0] eps, input int gap_mode,
                                input int stall_mode);
        int stop_at;
        start_phase(eps, gap_mode, stall_mode);
        stop_at = n_stim + PHASE_ITEMS;
        while (n_stim < stop_at) push_random_sequence();
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
            drain_hold = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                face_correction_predict(in_data);
                n_accepted++;
                if (in_data.axis == AXIS_Z && $urandom_range(0, 39) == 0) drain_hold = 1'b1;
            end
            if (!in_valid || !in_stall) begin
                if (drain_hold && exp_corrections.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    drain_hold = 1'b0;
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                    gap_left = pick_gap(src_gap_mode);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_correction(input t_out_item got);
        t_out_item want;
        if (exp_corrections.size() == 0) begin
            $error("unexpected result beat: correction %0d", got.correction);
            n_fail++;
            return;
        end
        want = exp_corrections.pop_front();
        if (got.correction !== want.correction) begin
            $error("correction: expected %0d, got %0d", want.correction, got.correction);
            n_fail++;
        end
        if (got.limiter_value !== want.limiter_value) begin
            $error("limiter_value: expected %0d, got %0d",
                   want.limiter_value, got.limiter_value);
            n_fail++;
        end
        if (got.ratio_saturated !== want.ratio_saturated) begin
            $error("ratio_saturated: expected %0d, got %0d",
                   want.ratio_saturated, got.ratio_saturated);
            n_fail++;
        end
    endtask

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) check_correction(out_data);
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(sink_stall_mode);
                if (stall_left > 0) begin
                    stall_left--;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog: cycles without any beat
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no beat for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed faces, eps at reset value
        for (int a = 0; a < 3; a++)   // zero numerator over zero denominator
            push_item(a, 1'b0, 1'b0, 0, 1, 0, 0, 0, 0, 0);
        for (int a = 0; a < 3; a++)   // interior, owner upwind, mid limiter band
            push_item(a, 1'b1, 1'b0, ONE, 3 * ONE, 0, ONE, ONE / 2,
                      (a + 1) * ONE / 4, -ONE);
        push_item(AXIS_NONE, 1'b1, 1'b1, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        for (int a = 0; a < 3; a++)   // boundary, owner upwind, negative over zero
            push_item(a, 1'b1, 1'b1, 5 * ONE, 5 * ONE - 1, 0, 7 * ONE, -ONE, ONE, 2 * ONE);
        for (int a = 0; a < 3; a++)   // boundary, neighbour upwind, quotient overflow
            push_item(a, 1'b0, 1'b1, 2 * ONE, 2 * ONE, 0, 100 * ONE, 3 * ONE,
                      -5 * ONE, 100 * ONE);
        for (int a = 0; a < 3; a++)   // full-scale fields
            push_item(a, 1'b0, 1'b0, Q_MAX_S, Q_MIN_S, Q_MIN_S, Q_MAX_S, Q_MAX_S,
                      Q_MIN_S, Q_MAX_S);
        // y and z without x, limiter on its 2r branch
        push_item(AXIS_Y, 1'b0, 1'b0, ONE, 0, ONE / 2, 0, ONE / 4, 0, -3 * ONE / 8);
        push_item(AXIS_Z, 1'b0, 1'b0, ONE, 0, ONE / 2, 0, ONE / 4, 0, -3 * ONE / 8);

        random_phase(16'd0, 1, 1);
        random_phase(16'hFFFF, 2, 0);

        start_phase(16'($urandom), 0, 0);
        push_acc_run(Q_MAX_S);
        push_acc_run(Q_MIN_S);

        random_phase(16'($urandom), 0, 2);
        random_phase(16'h8000, 1, 2);
        random_phase(16'($urandom_range(1, 64)), 2, 2);

        wait_idle();
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: tvd_mc_face_correction.f
rtl/tvdmc_pkg.sv
rtl/tvdmc_div.sv
rtl/tvd_mc_face_correction.sv
dv/tb_tvd_mc_face_correction.sv
